[src/tick_task_scheduler_table_core_assert.svh]
// Assertion macros for the scheduler table RTL.
// Included by files that check their own logic; empty when SYNTH is defined.
`ifndef TICK_TASK_SCHEDULER_TABLE_CORE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
// Clocked assertion with reset disable.
`define TTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rstn, prop, msg)
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/tts_pkg.sv]
// Types and constants for the tick task scheduler table.
// No dependencies; used by the core and the testbench.
package tts_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int SLOT_FW     = 5;

  localparam logic [SLOT_FW-1:0] NO_SLOT = 5'd16;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_DISP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL,
    ST_READ,
    ST_EXEC,
    ST_FIN
  } state_e;

  // One slot as stored in the slot RAM; the valid mark lives in flops.
  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } slot_ent_t;

endpackage

[src/tts_intf.sv]
// Valid/ready channel interfaces of the scheduler table: request in, result out.
// Stand-alone; field widths follow the item formats.
interface tts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  task_handle;
  logic [31:0] first_delay;
  logic [31:0] run_period;
  logic [3:0]  slot_index;

  modport source (output valid, kind, task_handle, first_delay, run_period, slot_index,
                  input ready);
  modport sink   (input valid, kind, task_handle, first_delay, run_period, slot_index,
                  output ready);
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot;
  logic [1:0] status;
  logic [7:0] handle_out;
  logic       task_ran;
  logic       last;

  modport source (output valid, slot, status, handle_out, task_ran, last, input ready);
  modport sink   (input valid, slot, status, handle_out, task_ran, last, output ready);
endinterface

[src/tick_task_scheduler_table_core.sv]
// Tick task scheduler table: task slots walked by a small sequencer over one slot RAM.
// Depends on tts_pkg, tts_intf.sv, tts_ram and the assertion macro header.
//
// A request is taken only while the core is idle; its results leave through an
// output register, so the next request may be taken while the final result still
// waits. A tick or a dispatch walks the slots in index order through one
// read-modify-write path on the slot RAM: an empty slot is skipped in the read
// state, an occupied one is read and then updated in the execute state (a dispatch
// also waits there while the result consumer stalls). An add scans the valid marks
// one slot a cycle and a delete clears its slot in the delete state; each then hands
// its result to the output register. A tick gives no result. A dispatch runs at
// most sixteen tasks per request; later ready tasks wait for the next dispatch.
`include "tick_task_scheduler_table_core_assert.svh"

module tick_task_scheduler_table_core #(
  parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tts_req_if.sink   req_i,
  tts_rsp_if.source rsp_o
);

  import tts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = $bits(slot_ent_t);

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SLOTS-1:0] valid_q, valid_d;

  // latched request
  kind_e       kind_q;
  logic [7:0]  handle_q;
  logic [31:0] delay_q;
  logic [31:0] period_q;
  logic [3:0]  sidx_q;

  // held result: last dispatched task, or the add/delete outcome
  logic               res_v_q, res_v_d;
  logic [SLOT_FW-1:0] res_slot_q, res_slot_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [7:0]         res_handle_q, res_handle_d;
  logic               res_ran_q, res_ran_d;

  // output register
  logic               out_v_q;
  logic [SLOT_FW-1:0] out_slot_q;
  logic [1:0]         out_status_q;
  logic [7:0]         out_handle_q;
  logic               out_ran_q;
  logic               out_last_q;

  logic               load_out;
  logic [SLOT_FW-1:0] ld_slot;
  logic [1:0]         ld_status;
  logic [7:0]         ld_handle;
  logic               ld_ran;
  logic               ld_last;

  logic       ram_we;
  logic       ram_re;
  slot_ent_t  ram_wdata;
  slot_ent_t  rd_ent;
  logic [ENT_W-1:0] rd_raw;

  logic               accept;
  logic               out_free;
  logic               done_walk;
  state_e             end_state;
  logic [IDX_W+4:0]   idx_ext;
  logic [SLOT_FW-1:0] idx_slot;
  logic               del_in_range;
  logic [IDX_W-1:0]   del_idx;

  assign accept       = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == ST_IDLE);
  assign out_free     = !out_v_q || rsp_o.ready;
  assign done_walk    = (idx_q == IDX_W'(SLOTS - 1));
  assign end_state    = (kind_q == KIND_TICK) ? ST_IDLE : ST_FIN;
  assign idx_ext      = {5'b0, idx_q};
  assign idx_slot     = idx_ext[SLOT_FW-1:0];
  assign del_in_range = (32'(sidx_q) < 32'(SLOTS));
  assign del_idx      = IDX_W'(sidx_q);
  assign rd_ent       = slot_ent_t'(rd_raw);

  tts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    res_v_d      = res_v_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_ran_d    = res_ran_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = rd_ent;
    load_out     = 1'b0;
    ld_slot      = res_slot_q;
    ld_status    = res_status_q;
    ld_handle    = res_handle_q;
    ld_ran       = res_ran_q;
    ld_last      = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          idx_d   = '0;
          cnt_d   = '0;
          res_v_d = 1'b0;
          case (kind_e'(req_i.kind))
            KIND_TICK: state_d = ST_READ;
            KIND_ADD:  state_d = ST_SCAN;
            KIND_DEL:  state_d = ST_DEL;
            KIND_DISP: state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (!valid_q[idx_q]) begin
          ram_we            = 1'b1;
          ram_wdata.handle  = handle_q;
          ram_wdata.delay   = delay_q;
          ram_wdata.period  = period_q;
          ram_wdata.pending = 8'd0;
          valid_d[idx_q]    = 1'b1;
          res_v_d      = 1'b1;
          res_slot_d   = idx_slot;
          res_status_d = STAT_OK;
          res_handle_d = 8'd0;
          res_ran_d    = 1'b0;
          state_d      = ST_FIN;
        end else if (done_walk) begin
          res_v_d      = 1'b1;
          res_slot_d   = NO_SLOT;
          res_status_d = STAT_FULL;
          res_handle_d = 8'd0;
          res_ran_d    = 1'b0;
          state_d      = ST_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_DEL: begin
        res_status_d = STAT_EMPTY;
        if (del_in_range) begin
          if (valid_q[del_idx]) begin
            res_status_d = STAT_OK;
          end
          valid_d[del_idx] = 1'b0;
        end
        res_v_d      = 1'b1;
        res_slot_d   = {1'b0, sidx_q};
        res_handle_d = 8'd0;
        res_ran_d    = 1'b0;
        state_d      = ST_FIN;
      end

      ST_READ: begin
        if (valid_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = ST_EXEC;
        end else if (done_walk) begin
          state_d = end_state;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_EXEC: begin
        if (kind_q == KIND_TICK) begin
          ram_we = 1'b1;
          if (rd_ent.delay == 32'd0) begin
            if (rd_ent.pending != 8'hFF) begin
              ram_wdata.pending = rd_ent.pending + 8'd1;
            end
            if (rd_ent.period != 32'd0) begin
              ram_wdata.delay = rd_ent.period;
            end
          end else begin
            ram_wdata.delay = rd_ent.delay - 32'd1;
          end
          if (done_walk) begin
            state_d = end_state;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end else if (rd_ent.pending != 8'd0) begin
          // hold while the previous task cannot move into the output register
          if (!res_v_q || out_free) begin
            if (res_v_q) begin
              load_out = 1'b1;
              ld_last  = 1'b0;
            end
            res_v_d      = 1'b1;
            res_slot_d   = idx_slot;
            res_status_d = STAT_OK;
            res_handle_d = rd_ent.handle;
            res_ran_d    = 1'b1;
            cnt_d        = cnt_q + 1'b1;
            if (rd_ent.period == 32'd0) begin
              valid_d[idx_q] = 1'b0;
            end else begin
              ram_we            = 1'b1;
              ram_wdata.pending = rd_ent.pending - 8'd1;
            end
            if (done_walk || (cnt_q == CNT_W'(MAX_RESULTS - 1))) begin
              state_d = ST_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_READ;
            end
          end
        end else if (done_walk) begin
          state_d = ST_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_READ;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          if (!res_v_q) begin
            ld_slot   = NO_SLOT;
            ld_status = STAT_OK;
            ld_handle = 8'd0;
            ld_ran    = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      valid_q <= '0;
      res_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      res_v_q <= res_v_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(req_i.kind);
      handle_q <= req_i.task_handle;
      delay_q  <= req_i.first_delay;
      period_q <= req_i.run_period;
      sidx_q   <= req_i.slot_index;
    end
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_ran_q    <= res_ran_d;
    if (load_out) begin
      out_slot_q   <= ld_slot;
      out_status_q <= ld_status;
      out_handle_q <= ld_handle;
      out_ran_q    <= ld_ran;
      out_last_q   <= ld_last;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.slot       = out_slot_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.handle_out = out_handle_q;
  assign rsp_o.task_ran   = out_ran_q;
  assign rsp_o.last       = out_last_q;

  `TTS_ASSERT(a_final_ends_item, clk_i, rst_ni, (load_out && ld_last) |=> (state_q == ST_IDLE), "final result loaded but sequencer still busy")
  `TTS_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> !req_i.ready, "request taken while previous one in progress")
  `TTS_ASSERT(a_add_marks_valid, clk_i, rst_ni, (state_q == ST_SCAN && ram_we) |=> valid_q[$past(idx_q)], "added slot not marked valid")
  `TTS_ASSERT(a_ram_write_owner, clk_i, rst_ni, ram_we |-> (state_q == ST_EXEC || state_q == ST_SCAN), "slot RAM written outside a slot update")
  `TTS_ASSERT_ALWAYS(a_idle_after_reset, clk_i, !rst_ni |=> (state_q == ST_IDLE || rst_ni), "sequencer not idle after reset")

endmodule

[src/tts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot records of the scheduler table.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/tick_task_scheduler_table_core_test.sv]
// Self-checking testbench for tick_task_scheduler_table_core: tick, add, delete, dispatch.
// Depends on tts_pkg and the request/result interfaces in tts_intf.sv; holds its own
// model of the slot table and compares every result transaction against it.
module tick_task_scheduler_table_core_test;
  import tts_pkg::*;

  localparam int SLOTS           = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 2 * SLOTS + 20;
  localparam int RANDOM_ITEMS    = 40;
  localparam int SATURATE_TICKS  = 256;

  typedef struct packed {
    logic [4:0] slot;
    logic [1:0] status;
    logic [7:0] handle_out;
    logic       task_ran;
    logic       last;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tts_req_if req_if ();
  tts_rsp_if rsp_if ();

  tick_task_scheduler_table_core #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slot table.
  logic        slot_busy   [SLOTS];
  logic [7:0]  slot_hdl    [SLOTS];
  logic [31:0] slot_wait   [SLOTS];
  logic [31:0] slot_reload [SLOTS];
  logic [7:0]  slot_runs   [SLOTS];

  sched_result_t expected_results_q[$];
  int unsigned   error_count = 0;
  int unsigned   burst_left  = 0;

  function automatic void wipe_slot(int i);
    slot_busy[i]   = 1'b0;
    slot_hdl[i]    = '0;
    slot_wait[i]   = '0;
    slot_reload[i] = '0;
    slot_runs[i]   = '0;
  endfunction

  function automatic sched_result_t make_result(logic [4:0] slot, logic [1:0] status,
                                                logic [7:0] hdl, logic ran, logic last);
    sched_result_t res;
    res.slot       = slot;
    res.status     = status;
    res.handle_out = hdl;
    res.task_ran   = ran;
    res.last       = last;
    return res;
  endfunction

  // Advance the shadow table by one accepted request and queue its results.
  function automatic void predict_schedule(kind_e kind, logic [7:0] hdl, logic [31:0] dly,
                                           logic [31:0] per, logic [3:0] idx);
    int free_slot;
    int ready_cnt;
    int runs;
    logic [1:0] del_status;
    free_slot = -1;
    ready_cnt = 0;
    runs      = 0;
    case (kind)
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (slot_wait[i] == 32'd0) begin
              if (slot_runs[i] != 8'hFF) slot_runs[i]++;
              if (slot_reload[i] != 32'd0) slot_wait[i] = slot_reload[i];
            end else begin
              slot_wait[i]--;
            end
          end
        end
      end
      KIND_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) free_slot = i;
        if (free_slot < 0) begin
          expected_results_q.push_back(make_result(NO_SLOT, STAT_FULL, 8'd0, 1'b0, 1'b1));
        end else begin
          slot_busy[free_slot]   = 1'b1;
          slot_hdl[free_slot]    = hdl;
          slot_wait[free_slot]   = dly;
          slot_reload[free_slot] = per;
          slot_runs[free_slot]   = 8'd0;
          expected_results_q.push_back(make_result(5'(free_slot), STAT_OK, 8'd0, 1'b0, 1'b1));
        end
      end
      KIND_DEL: begin
        del_status = STAT_EMPTY;
        if (int'(idx) < SLOTS) begin
          if (slot_busy[idx]) del_status = STAT_OK;
          wipe_slot(int'(idx));
        end
        expected_results_q.push_back(make_result(5'(idx), del_status, 8'd0, 1'b0, 1'b1));
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_runs[i] != 8'd0) ready_cnt++;
        if (ready_cnt > MAX_RESULTS) ready_cnt = MAX_RESULTS;
        if (ready_cnt == 0)
          expected_results_q.push_back(make_result(NO_SLOT, STAT_OK, 8'd0, 1'b0, 1'b1));
        for (int i = 0; i < SLOTS && runs < ready_cnt; i++) begin
          if (slot_runs[i] != 8'd0) begin
            runs++;
            expected_results_q.push_back(make_result(5'(i), STAT_OK, slot_hdl[i], 1'b1,
                                                     runs == ready_cnt));
            slot_runs[i]--;
            // one-shot tasks leave the table once they run
            if (slot_reload[i] == 32'd0) wipe_slot(i);
          end
        end
      end
    endcase
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  function automatic void check_result(sched_result_t got);
    sched_result_t want;
    if (expected_results_q.size() == 0) begin
      flag_error($sformatf("unexpected result slot=%0d status=%0d handle=%0d ran=%0d last=%0d",
                           got.slot, got.status, got.handle_out, got.task_ran, got.last));
      return;
    end
    want = expected_results_q.pop_front();
    if (got.slot !== want.slot)
      flag_error($sformatf("slot expected %0d got %0d", want.slot, got.slot));
    if (got.status !== want.status)
      flag_error($sformatf("status expected %0d got %0d", want.status, got.status));
    if (got.handle_out !== want.handle_out)
      flag_error($sformatf("handle_out expected %0d got %0d", want.handle_out, got.handle_out));
    if (got.task_ran !== want.task_ran)
      flag_error($sformatf("task_ran expected %0d got %0d", want.task_ran, got.task_ran));
    if (got.last !== want.last)
      flag_error($sformatf("last expected %0d got %0d", want.last, got.last));
  endfunction

  // Result side: check each accepted transaction.
  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      check_result(make_result(rsp_if.slot, rsp_if.status, rsp_if.handle_out,
                               rsp_if.task_ran, rsp_if.last));
  end

  // Result side stalls: a rotating ready pattern, reloaded at random when its phase counter runs out.
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_phase   = 0;

  always @(posedge clk_i) begin
    if (ready_phase == 0) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      ready_phase   <= 63;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      ready_phase   <= ready_phase - 1;
    end
    rsp_if.ready <= ready_pattern[0];
  end

  // Send one request, predict it on acceptance, then pace the next burst.
  task automatic send_item(input kind_e kind, input logic [7:0] hdl, input logic [31:0] dly,
                           input logic [31:0] per, input logic [3:0] idx);
    int unsigned gap;
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.task_handle <= hdl;
    req_if.first_delay <= dly;
    req_if.run_period  <= per;
    req_if.slot_index  <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_schedule(kind, hdl, dly, per, idx);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 7);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Tick or dispatch with random content in the fields it ignores.
  task automatic send_bare(input kind_e kind);
    send_item(kind, 8'($urandom()), $urandom(), $urandom(), 4'($urandom()));
  endtask

  function automatic logic [31:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'd0;
    if (r < 85) return 32'($urandom_range(1, 5));
    if (r < 92) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic test_basic_ops();
    send_bare(KIND_DISP);  // nothing pending
    send_item(KIND_DEL, 8'h00, 32'd0, 32'd0, 4'd0);
    send_item(KIND_DEL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_item(KIND_ADD, 8'h00, 32'd0, 32'd0, 4'd0);
    send_item(KIND_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_item(KIND_ADD, 8'h5A, 32'd1, 32'd2, 4'd7);
    // delay zero with no period keeps gaining runs on every tick
    send_bare(KIND_TICK);
    send_bare(KIND_TICK);
    send_bare(KIND_DISP);
    send_item(KIND_DEL, 8'h00, 32'd0, 32'd0, 4'd1);
    send_item(KIND_ADD, 8'hA5, 32'd0, 32'd1, 4'd0);
    send_bare(KIND_TICK);
    send_bare(KIND_TICK);
    send_bare(KIND_TICK);
    send_bare(KIND_DISP);
    send_item(KIND_DEL, 8'h00, 32'd0, 32'd0, 4'd0);
    send_item(KIND_DEL, 8'h00, 32'd0, 32'd0, 4'd2);
  endtask

  task automatic test_table_full();
    // one add more than there are slots; every slot ready on the next tick
    for (int i = 0; i <= SLOTS; i++)
      send_item(KIND_ADD, 8'($urandom()), 32'd0, 32'(i % 2), 4'($urandom()));
    send_bare(KIND_TICK);
    send_bare(KIND_DISP);
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_bare(KIND_TICK);
      else if (pick < 60)
        send_item(KIND_ADD, 8'($urandom()), pick_span(), pick_span(), 4'($urandom()));
      else if (pick < 72)
        send_item(KIND_DEL, 8'($urandom()), $urandom(), $urandom(),
                  4'($urandom_range(0, SLOTS - 1)));
      else
        send_bare(KIND_DISP);
    end
  endtask

  task automatic test_pending_saturation();
    // free the lowest slot so the add below lands there
    send_item(KIND_DEL, 8'($urandom()), $urandom(), $urandom(), 4'd0);
    send_item(KIND_ADD, 8'($urandom()), 32'd0, 32'd0, 4'd0);
    // a wrapping count would be back at zero after this many ticks
    repeat (SATURATE_TICKS) send_bare(KIND_TICK);
    send_bare(KIND_DISP);
    send_bare(KIND_DISP);
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = KIND_TICK;
    req_if.task_handle = '0;
    req_if.first_delay = '0;
    req_if.run_period  = '0;
    req_if.slot_index  = '0;
    rsp_if.ready       = 1'b0;
    for (int i = 0; i < SLOTS; i++) wipe_slot(i);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_table_full();
    test_random_mix();
    test_pending_saturation();

    req_if.valid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    error_count += expected_results_q.size();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
